### rtl/core/tvps_pkg.sv
// ----------------------------------------------------------------------------
// tvps_pkg: shared types and constants
// Opcodes, register indexes, reset values and field widths for the valve
// pulse sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package tvps_pkg;

    localparam int unsigned TIME_W   = 32;   // timestamp width, ms
    localparam int unsigned REG_W    = 16;   // configuration register width
    localparam int unsigned OP_W     = 2;
    localparam int unsigned IDX_W    = 3;
    localparam int unsigned OUT_W    = 5;
    localparam int unsigned OUT_BYTES_W = 8;
    localparam int unsigned DIV_W    = REG_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

    localparam logic [REG_W-1:0] RST_PUSH_DURATION = REG_W'(1000);
    localparam logic [REG_W-1:0] RST_BALANCE_DELAY = REG_W'(10);
    localparam logic [REG_W-1:0] RST_NORMAL_WINDOW = REG_W'(200);
    localparam logic [REG_W-1:0] RST_NORMAL_ALT    = REG_W'(100);
    localparam logic [REG_W-1:0] RST_GLOBAL_WINDOW = REG_W'(5000);
    localparam logic [REG_W-1:0] RST_GLOBAL_ALT    = REG_W'(500);

    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 2'd0,
        OP_START  = 2'd1,
        OP_CANCEL = 2'd2,
        OP_FORCE  = 2'd3
    } t_opcode;

    typedef enum logic [IDX_W-1:0] {
        CFG_PUSH_DURATION     = 3'd0,
        CFG_BALANCE_DELAY     = 3'd1,
        CFG_NORMAL_WINDOW     = 3'd2,
        CFG_NORMAL_ALT_PERIOD = 3'd3,
        CFG_GLOBAL_WINDOW     = 3'd4,
        CFG_GLOBAL_ALT_PERIOD = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [REG_W-1:0] push_duration;
        logic [REG_W-1:0] balance_delay;
        logic [REG_W-1:0] normal_window;
        logic [REG_W-1:0] normal_alt_period;
        logic [REG_W-1:0] global_window;
        logic [REG_W-1:0] global_alt_period;
    } t_cfg;

    // bit positions in the result word
    localparam int unsigned OB_PUMP    = 0;
    localparam int unsigned OB_VALVE_C = 1;
    localparam int unsigned OB_VALVE_D = 2;
    localparam int unsigned OB_RUNNING = 3;
    localparam int unsigned OB_BALANCE = 4;

endpackage

`default_nettype wire

### rtl/core/tvps_cfg_regs.sv
// ----------------------------------------------------------------------------
// tvps_cfg_regs: configuration register file
// Six 16-bit timing registers written through a valid/ready channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tvps_cfg_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [tvps_pkg::IDX_W-1:0]  i_cfg_index,
    input  wire logic [tvps_pkg::REG_W-1:0]  i_cfg_data,
    output tvps_pkg::t_cfg                   o_cfg
);
    import tvps_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.push_duration     <= RST_PUSH_DURATION;
            r_cfg.balance_delay     <= RST_BALANCE_DELAY;
            r_cfg.normal_window     <= RST_NORMAL_WINDOW;
            r_cfg.normal_alt_period <= RST_NORMAL_ALT;
            r_cfg.global_window     <= RST_GLOBAL_WINDOW;
            r_cfg.global_alt_period <= RST_GLOBAL_ALT;
        end else if (i_cfg_valid) begin
            // drop writes beyond the register list
            unique case (i_cfg_index)
                CFG_PUSH_DURATION:     r_cfg.push_duration     <= i_cfg_data;
                CFG_BALANCE_DELAY:     r_cfg.balance_delay     <= i_cfg_data;
                CFG_NORMAL_WINDOW:     r_cfg.normal_window     <= i_cfg_data;
                CFG_NORMAL_ALT_PERIOD: r_cfg.normal_alt_period <= i_cfg_data;
                CFG_GLOBAL_WINDOW:     r_cfg.global_window     <= i_cfg_data;
                CFG_GLOBAL_ALT_PERIOD: r_cfg.global_alt_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/core/tvps_div.sv
// ----------------------------------------------------------------------------
// tvps_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, done pulse at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module tvps_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [tvps_pkg::DIV_W-1:0]     i_dividend,
    input  wire logic [tvps_pkg::DIV_W-1:0]     i_divisor,
    output logic                                o_done,
    output logic [tvps_pkg::DIV_W-1:0]          o_quotient
);
    import tvps_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_quo;
    logic [DIV_W-1:0]     r_dvs;

    logic [DIV_W:0]       rem_sh;
    logic [DIV_W:0]       rem_sub;
    logic                 fits;

    always_comb begin
        rem_sh  = {r_rem, r_quo[DIV_W-1]};
        rem_sub = rem_sh - {1'b0, r_dvs};
        fits    = (rem_sh >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

### rtl/core/timed_valve_pulse_sequencer.sv
// ----------------------------------------------------------------------------
// timed_valve_pulse_sequencer: pump and valve timing for a turn actuator
// Applies tick, start, cancel and force-balance commands and reports the
// pump and valve drive after each one.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: s_axis_tuser carries the opcode (tick, start, cancel,
//   force balance), s_axis_tdata the millisecond timestamp used by ticks.
//   Output stream: one 8-bit result per input transfer, holding pump, valve
//   C, valve D, running and balancing flags from bit 0 up.
//   Configuration: i_cfg_valid / i_cfg_index / i_cfg_data write one of the
//   six timing registers per transfer; o_cfg_ready is always high. Write
//   only while no command is in flight.
//   Sequence: start, cancel, force balance and a tick outside balance go
//   from the apply state to the output state. A tick while balancing, or
//   one that ends the push, also passes the balance and window states,
//   and the divide state when the valve phase comes from a 16-step
//   restoring divider that handles one quotient bit per cycle. One command
//   is in work at a time; s_axis_tready is high only while the sequencer idles.
//   Stall: a finished result waits in the output register while the next
//   command is taken; a second result holds in the sequencer until the
//   receiver takes the first.
//   Reset (synchronous, active low) clears all phases and loads the
//   default timing registers.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_valve_pulse_sequencer (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // input stream
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [tvps_pkg::TIME_W-1:0]      s_axis_tdata,  // [31:0] now_ms
    input  wire logic [tvps_pkg::OP_W-1:0]        s_axis_tuser,  // [1:0] opcode
    // result stream
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [0] pump_on, [1] valve_c_on, [2] valve_d_on, [3] is_running,
    // [4] is_balancing, [7:5] zero
    output logic [tvps_pkg::OUT_BYTES_W-1:0]      m_axis_tdata,
    // configuration write channel
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [tvps_pkg::IDX_W-1:0]       i_cfg_index,
    input  wire logic [tvps_pkg::REG_W-1:0]       i_cfg_data
);
    import tvps_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_APPLY = 6'b000010,
        S_BAL   = 6'b000100,
        S_WIN   = 6'b001000,
        S_DIV   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_cfg cfg;

    t_state            r_state;
    t_opcode           r_op;
    logic [TIME_W-1:0] r_now;
    logic [TIME_W-1:0] r_elapsed;

    // actuator state
    logic              r_push_active;
    logic              r_bal_active;
    logic              r_win_open;
    logic              r_alt_phase;
    logic              r_force_pend;
    logic [TIME_W-1:0] r_push_start;
    logic [TIME_W-1:0] r_bal_start;
    logic [REG_W-1:0]  r_act_alt;
    logic [REG_W-1:0]  r_act_win;

    // result register
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out;

    // datapath terms
    logic [TIME_W-1:0] push_start_eff;
    logic [TIME_W-1:0] push_elapsed;
    logic              push_done;
    logic [TIME_W-1:0] bal_start_eff;
    logic [REG_W:0]    win_end;
    logic              win_open;
    logic              win_over;
    logic [DIV_W-1:0]  win_offset;
    logic              div_start;
    logic              div_done;
    logic [DIV_W-1:0]  div_quo;
    logic              out_free;
    logic [OUT_W-1:0]  result;

    tvps_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tvps_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (win_offset),
        .i_divisor  (r_act_alt),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        // push is timed from the first tick with a nonzero timestamp
        push_start_eff = (r_push_start == '0) ? r_now : r_push_start;
        push_elapsed   = r_now - push_start_eff;
        push_done      = r_push_active && (push_start_eff != '0) &&
                         (push_elapsed >= TIME_W'(cfg.push_duration));

        // a forced window starts at the first tick after the request
        bal_start_eff  = r_force_pend ? r_now : r_bal_start;

        win_end  = {1'b0, cfg.balance_delay} + {1'b0, r_act_win};
        win_open = (r_elapsed >= TIME_W'(cfg.balance_delay)) &&
                   (r_elapsed <  TIME_W'(win_end));
        win_over = (r_elapsed >= TIME_W'(win_end));
        // inside the window the offset is below the window length
        win_offset = r_elapsed[DIV_W-1:0] - cfg.balance_delay;

        div_start = (r_state == S_WIN) && win_open && (r_act_alt != '0);

        result              = '0;
        result[OB_PUMP]     = r_push_active;
        result[OB_VALVE_C]  = r_push_active || (r_bal_active && r_win_open && !r_alt_phase);
        result[OB_VALVE_D]  = r_push_active || (r_bal_active && r_win_open && r_alt_phase);
        result[OB_RUNNING]  = r_push_active;
        result[OB_BALANCE]  = r_bal_active;

        out_free = !r_out_valid || m_axis_tready;
    end

    // sequencer and actuator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_push_active <= 1'b0;
            r_bal_active  <= 1'b0;
            r_win_open    <= 1'b0;
            r_alt_phase   <= 1'b0;
            r_force_pend  <= 1'b0;
            r_push_start  <= '0;
            r_bal_start   <= '0;
            r_act_alt     <= RST_NORMAL_ALT;
            r_act_win     <= RST_NORMAL_WINDOW;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    unique case (r_op)
                        OP_TICK: begin
                            if (r_push_active && r_push_start == '0) begin
                                r_push_start <= r_now;
                            end
                            if (push_done) begin
                                // push over: enter normal balance
                                r_push_active <= 1'b0;
                                r_bal_active  <= 1'b1;
                                r_force_pend  <= 1'b0;
                                r_win_open    <= 1'b0;
                                r_alt_phase   <= 1'b0;
                                r_bal_start   <= r_now;
                                r_act_alt     <= cfg.normal_alt_period;
                                r_act_win     <= cfg.normal_window;
                            end
                            r_state <= (push_done || r_bal_active) ? S_BAL : S_OUT;
                        end
                        OP_START: begin
                            r_push_active <= 1'b1;
                            r_bal_active  <= 1'b0;
                            r_force_pend  <= 1'b0;
                            r_win_open    <= 1'b0;
                            r_alt_phase   <= 1'b0;
                            r_push_start  <= '0;
                            r_state       <= S_OUT;
                        end
                        OP_CANCEL: begin
                            r_push_active <= 1'b0;
                            r_bal_active  <= 1'b0;
                            r_force_pend  <= 1'b0;
                            r_win_open    <= 1'b0;
                            r_alt_phase   <= 1'b0;
                            r_push_start  <= '0;
                            r_bal_start   <= '0;
                            r_state       <= S_OUT;
                        end
                        OP_FORCE: begin
                            r_push_active <= 1'b0;
                            r_bal_active  <= 1'b1;
                            r_force_pend  <= 1'b1;
                            r_win_open    <= 1'b0;
                            r_alt_phase   <= 1'b0;
                            r_push_start  <= '0;
                            r_bal_start   <= '0;
                            r_act_alt     <= cfg.global_alt_period;
                            r_act_win     <= cfg.global_window;
                            r_state       <= S_OUT;
                        end
                        default: r_state <= S_OUT;
                    endcase
                end
                S_BAL: begin
                    if (r_force_pend) begin
                        r_bal_start  <= r_now;
                        r_force_pend <= 1'b0;
                    end
                    r_elapsed <= r_now - bal_start_eff;
                    r_state   <= S_WIN;
                end
                S_WIN: begin
                    r_win_open <= win_open;
                    if (win_over) begin
                        r_bal_active <= 1'b0;
                        r_alt_phase  <= 1'b0;
                    end
                    if (win_open && r_act_alt == '0) begin
                        // zero period holds valve C open
                        r_alt_phase <= 1'b0;
                    end
                    r_state <= div_start ? S_DIV : S_OUT;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_alt_phase <= div_quo[0];
                        r_state     <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // command capture, payload only
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && s_axis_tvalid) begin
            r_op  <= t_opcode'(s_axis_tuser);
            r_now <= s_axis_tdata;
        end
    end

    // result register: hold until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_out <= result;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_BYTES_W - OUT_W){1'b0}}, r_out};

`ifndef ASSERT_OFF
    a_phase_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_push_active && r_bal_active))
        else $error("push and balance phases active together");

    a_both_valves_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out[OB_VALVE_C] && r_out[OB_VALVE_D]) |-> r_out[OB_PUMP])
        else $error("both valves open outside the push phase");

    a_pump_not_bal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out[OB_PUMP]) |-> !r_out[OB_BALANCE])
        else $error("pump driven while balancing");

    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && div_done) |=> (r_state == S_OUT))
        else $error("sequencer missed divider completion");

    a_accept_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == S_APPLY))
        else $error("accepted command not applied");
`endif

endmodule

`default_nettype wire

### test/valve_drive_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// valve_drive_checker: result predictor and scoreboard for the sequencer
// Watches the command, result and configuration channels. Each accepted
// command is run through a local model of the push and balance timing. The
// model yields the pump and valve drive that its result must carry.
// ----------------------------------------------------------------------------

module valve_drive_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // command stream
    input  wire logic                          i_cmd_valid,
    input  wire logic                          i_cmd_ready,
    input  wire logic [tvps_pkg::TIME_W-1:0]   i_cmd_time,
    input  wire logic [tvps_pkg::OP_W-1:0]     i_cmd_op,
    // result stream
    input  wire logic                          i_drive_valid,
    input  wire logic                          i_drive_ready,
    input  wire logic [tvps_pkg::OUT_BYTES_W-1:0] i_drive_data,
    // configuration writes
    input  wire logic                          i_cfg_valid,
    input  wire logic                          i_cfg_ready,
    input  wire logic [tvps_pkg::IDX_W-1:0]    i_cfg_index,
    input  wire logic [tvps_pkg::REG_W-1:0]    i_cfg_data,
    output int unsigned                        o_outstanding,
    output int unsigned                        o_mismatches
);
    import tvps_pkg::*;

    typedef struct packed {
        logic balancing;
        logic running;
        logic valve_d;
        logic valve_c;
        logic pump;
    } t_drive;

    t_cfg              timing;
    logic              pushing, balancing, window_on, odd_phase, force_armed;
    logic [TIME_W-1:0] push_origin, balance_origin;
    logic [REG_W-1:0]  live_period, live_window;
    t_drive            pending_drive[$];
    int unsigned       mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    function automatic void clear_sequencer();
        timing.push_duration     = RST_PUSH_DURATION;
        timing.balance_delay     = RST_BALANCE_DELAY;
        timing.normal_window     = RST_NORMAL_WINDOW;
        timing.normal_alt_period = RST_NORMAL_ALT;
        timing.global_window     = RST_GLOBAL_WINDOW;
        timing.global_alt_period = RST_GLOBAL_ALT;
        pushing        = 1'b0;
        balancing      = 1'b0;
        window_on      = 1'b0;
        odd_phase      = 1'b0;
        force_armed    = 1'b0;
        push_origin    = '0;
        balance_origin = '0;
        live_period    = RST_NORMAL_ALT;
        live_window    = RST_NORMAL_WINDOW;
    endfunction

    function automatic void load_register(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
        case (idx)
            CFG_PUSH_DURATION:     timing.push_duration     = val;
            CFG_BALANCE_DELAY:     timing.balance_delay     = val;
            CFG_NORMAL_WINDOW:     timing.normal_window     = val;
            CFG_NORMAL_ALT_PERIOD: timing.normal_alt_period = val;
            CFG_GLOBAL_WINDOW:     timing.global_window     = val;
            CFG_GLOBAL_ALT_PERIOD: timing.global_alt_period = val;
            default: ;
        endcase
    endfunction

    // Elapsed times wrap at 32 bits; the window end never exceeds 17 bits.
    function automatic void advance_clock(logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] elapsed, win_end, into_window;
        if (pushing && push_origin == '0)
            push_origin = now;
        if (pushing && push_origin != '0 &&
            (now - push_origin) >= {16'b0, timing.push_duration}) begin
            pushing        = 1'b0;
            balancing      = 1'b1;
            force_armed    = 1'b0;
            window_on      = 1'b0;
            odd_phase      = 1'b0;
            balance_origin = now;
            live_period    = timing.normal_alt_period;
            live_window    = timing.normal_window;
        end
        if (balancing) begin
            if (force_armed) begin
                balance_origin = now;
                force_armed    = 1'b0;
            end
            elapsed   = now - balance_origin;
            win_end   = {16'b0, timing.balance_delay} + {16'b0, live_window};
            window_on = elapsed >= {16'b0, timing.balance_delay} && elapsed < win_end;
            if (window_on) begin
                into_window = elapsed - {16'b0, timing.balance_delay};
                if (live_period != '0)
                    odd_phase = ((into_window / {16'b0, live_period}) & 32'd1) != 32'd0;
                else
                    odd_phase = 1'b0;
            end
            if (elapsed >= win_end) begin
                balancing = 1'b0;
                window_on = 1'b0;
                odd_phase = 1'b0;
            end
        end
    endfunction

    function automatic t_drive apply_command(t_opcode op, logic [TIME_W-1:0] now);
        t_drive d;
        case (op)
            OP_TICK: advance_clock(now);
            OP_START: begin
                pushing     = 1'b1;
                balancing   = 1'b0;
                force_armed = 1'b0;
                window_on   = 1'b0;
                odd_phase   = 1'b0;
                push_origin = '0;
            end
            OP_CANCEL: begin
                pushing        = 1'b0;
                balancing      = 1'b0;
                force_armed    = 1'b0;
                window_on      = 1'b0;
                odd_phase      = 1'b0;
                push_origin    = '0;
                balance_origin = '0;
            end
            default: begin
                pushing        = 1'b0;
                balancing      = 1'b1;
                force_armed    = 1'b1;
                window_on      = 1'b0;
                odd_phase      = 1'b0;
                push_origin    = '0;
                balance_origin = '0;
                live_period    = timing.global_alt_period;
                live_window    = timing.global_window;
            end
        endcase
        d.pump      = pushing;
        d.valve_c   = pushing || (balancing && window_on && !odd_phase);
        d.valve_d   = pushing || (balancing && window_on && odd_phase);
        d.running   = pushing;
        d.balancing = balancing;
        return d;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_drive want;
        if (!i_rst_n) begin
            clear_sequencer();
            pending_drive.delete();
        end else begin
            // retire the result first: a command is never answered in the cycle that accepts it
            if (i_drive_valid && i_drive_ready) begin
                if (pending_drive.size() == 0) begin
                    $display("%0t ns: result %02h with none expected", $time, i_drive_data);
                    mismatch_count++;
                end else begin
                    want = pending_drive.pop_front();
                    check_field("pump_on",      8'(want.pump),
                                8'(i_drive_data[OB_PUMP]));
                    check_field("valve_c_on",   8'(want.valve_c),
                                8'(i_drive_data[OB_VALVE_C]));
                    check_field("valve_d_on",   8'(want.valve_d),
                                8'(i_drive_data[OB_VALVE_D]));
                    check_field("is_running",   8'(want.running),
                                8'(i_drive_data[OB_RUNNING]));
                    check_field("is_balancing", 8'(want.balancing),
                                8'(i_drive_data[OB_BALANCE]));
                    check_field("padding", 8'h00, {5'b0, i_drive_data[7:5]});
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                load_register(i_cfg_index, i_cfg_data);
            if (i_cmd_valid && i_cmd_ready)
                pending_drive.push_back(apply_command(t_opcode'(i_cmd_op), i_cmd_time));
        end
        o_outstanding <= pending_drive.size();
    end

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: regression bench for the timed valve pulse sequencer
// Drives a directed walk through push, balance, forced balance, wrap and
// cancel, then phases of random command sequences under several timing
// settings and handshake pressure. The checker beside the block predicts
// every result; this module only makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------

module tb;
    import tvps_pkg::*;

    localparam int unsigned RESET_CYCLES = 6;
    localparam int unsigned RANDOM_CMDS  = 550;
    localparam int unsigned PHASES       = 8;
    localparam int unsigned SETTLE       = 30;
    localparam int unsigned QUIET_LIMIT  = 4000;  // cycles with no transfer at all

    // indexes past the register list; writes there must be dropped
    localparam logic [IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                   i_clk   = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [TIME_W-1:0]      s_tdata = '0;       // [31:0] now_ms
    logic [OP_W-1:0]        s_tuser = OP_TICK;  // [1:0] opcode
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_BYTES_W-1:0] m_tdata;            // [0] pump .. [4] balancing
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [IDX_W-1:0]       cfg_index = '0;
    logic [REG_W-1:0]       cfg_data  = '0;

    int unsigned outstanding, mismatches;
    int unsigned src_idle   = 0;   // percent of cycles the sender holds off
    int unsigned sink_stall = 0;   // percent of cycles the receiver stalls
    int unsigned step_max   = 1;   // largest tick advance, scaled to the timing
    int unsigned cmds_sent  = 0;
    int unsigned quiet_cycles = 0;

    always #6 i_clk = ~i_clk;

    timed_valve_pulse_sequencer u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_tvalid),
        .s_axis_tready(s_tready),
        .s_axis_tdata (s_tdata),
        .s_axis_tuser (s_tuser),
        .m_axis_tvalid(m_tvalid),
        .m_axis_tready(m_tready),
        .m_axis_tdata (m_tdata),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    valve_drive_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (s_tvalid),
        .i_cmd_ready  (s_tready),
        .i_cmd_time   (s_tdata),
        .i_cmd_op     (s_tuser),
        .i_drive_valid(m_tvalid),
        .i_drive_ready(m_tready),
        .i_drive_data (m_tdata),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_outstanding(outstanding),
        .o_mismatches (mismatches)
    );

    // Receiver: stall at random, at the rate the current phase asks.
    always @(posedge i_clk)
        m_tready <= ($urandom_range(0, 99) >= sink_stall);

    // Watchdog: any transfer on any channel restarts the count.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one command and hold it until the transfer. tvalid stays high on
    // return so a following command can go out back to back.
    task automatic send_cmd(input t_opcode op, input logic [TIME_W-1:0] now);
        while ($urandom_range(0, 99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= now;
        s_tuser  <= op;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        cmds_sent++;
    endtask

    // Drop tvalid and hold off until every result has been taken.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    // Hold cfg_valid across a batch of writes; the caller lowers it.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
    endtask

    // Phase 0 takes every register to zero, phase 1 to all ones, the rest
    // get small random values so that sequences finish in a few ticks.
    task automatic program_timing(input int unsigned phase);
        logic [REG_W-1:0] push, delay, nwin, nalt, gwin, galt;
        if (phase == 0) begin
            {push, delay, nwin, nalt, gwin, galt} = '0;
        end else if (phase == 1) begin
            {push, delay, nwin, nalt, gwin, galt} = '1;
        end else begin
            push  = REG_W'($urandom_range(0, 60));
            delay = REG_W'($urandom_range(0, 20));
            nwin  = ($urandom_range(0, 5) == 0) ? '0 : REG_W'($urandom_range(1, 80));
            nalt  = ($urandom_range(0, 4) == 0) ? '0 : REG_W'($urandom_range(1, 15));
            gwin  = ($urandom_range(0, 5) == 0) ? '0 : REG_W'($urandom_range(1, 120));
            galt  = ($urandom_range(0, 4) == 0) ? '0 : REG_W'($urandom_range(1, 20));
        end
        // stray writes first: they must leave the real registers untouched
        write_reg(CFG_SPARE_LO, REG_W'($urandom));
        write_reg(CFG_SPARE_HI, REG_W'($urandom));
        write_reg(CFG_PUSH_DURATION,     push);
        write_reg(CFG_BALANCE_DELAY,     delay);
        write_reg(CFG_NORMAL_WINDOW,     nwin);
        write_reg(CFG_NORMAL_ALT_PERIOD, nalt);
        write_reg(CFG_GLOBAL_WINDOW,     gwin);
        write_reg(CFG_GLOBAL_ALT_PERIOD, galt);
        cfg_valid <= 1'b0;
        step_max = (int'(push) + int'(delay) + int'(nwin > gwin ? nwin : gwin)) / 8 + 1;
    endtask

    // One well-formed run: start or force, then a train of rising ticks.
    // Mix in stray commands, steps back in time and drained pauses.
    task automatic run_sequence();
        logic [TIME_W-1:0] clock_ms;
        int unsigned       roll;
        roll = $urandom_range(0, 7);
        if (roll == 0)
            clock_ms = '0;
        else if (roll < 3)
            clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 4 * step_max);
        else
            clock_ms = $urandom;
        if ($urandom_range(0, 3) == 0)
            send_cmd(OP_FORCE, $urandom);
        else
            send_cmd(OP_START, $urandom);
        if (roll == 0)
            send_cmd(OP_TICK, '0);
        repeat ($urandom_range(4, 16)) begin
            if ($urandom_range(0, 11) == 0)
                send_cmd(t_opcode'($urandom_range(0, 3)), $urandom);
            if ($urandom_range(0, 29) == 0)
                wait_drained();
            if ($urandom_range(0, 15) == 0)
                clock_ms = clock_ms - $urandom_range(1, step_max);
            else
                clock_ms = clock_ms + $urandom_range(0, step_max);
            send_cmd(OP_TICK, clock_ms);
        end
    endtask

    initial begin
        logic [TIME_W-1:0] t0, tb0;
        int unsigned       quota;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed walk on the reset timing: push 1000, delay 10,
        // ---- window 200, period 100, forced window 5000, period 500
        t0 = 32'hFFFF_FF00;
        send_cmd(OP_TICK,  '0);           // idle tick changes nothing
        send_cmd(OP_START, '1);           // start ignores its timestamp
        send_cmd(OP_TICK,  '0);           // zero time leaves the push untimed
        send_cmd(OP_TICK,  t0);           // push timed from here
        send_cmd(OP_TICK,  t0 + 500);     // elapsed time across the wrap
        tb0 = t0 + 1000;
        send_cmd(OP_TICK,  tb0);          // push ends, balance begins
        send_cmd(OP_TICK,  tb0 + 9);      // still in the delay
        send_cmd(OP_TICK,  tb0 + 10);     // window opens on valve C
        send_cmd(OP_TICK,  tb0 + 110);    // second period on valve D
        send_cmd(OP_TICK,  tb0 + 209);    // last ms of the window
        send_cmd(OP_TICK,  tb0 + 210);    // window closed, balance over
        send_cmd(OP_FORCE, '1);
        tb0 = 32'h8000_0000;
        send_cmd(OP_TICK,  tb0);          // forced window starts at this tick
        send_cmd(OP_TICK,  tb0 + 10);
        send_cmd(OP_TICK,  tb0 + 510);
        send_cmd(OP_TICK,  tb0 + 5009);
        send_cmd(OP_TICK,  tb0 + 5010);
        send_cmd(OP_FORCE, 32'h5555_5555);
        send_cmd(OP_CANCEL, 32'hAAAA_AAAA);
        send_cmd(OP_START, '0);
        send_cmd(OP_TICK,  32'h5555_5555);
        send_cmd(OP_FORCE, '0);           // force cuts a push short
        send_cmd(OP_START, '0);
        send_cmd(OP_CANCEL, '0);

        // ---- random phases: each a new timing set, one of four pressure settings
        for (int unsigned phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            case (phase % 4)
                0: begin src_idle = 0;  sink_stall = 0;  end
                1: begin src_idle = 62; sink_stall = 0;  end
                2: begin src_idle = 0;  sink_stall = 62; end
                default: begin src_idle = 21; sink_stall = 21; end
            endcase
            program_timing(phase);
            quota = cmds_sent + RANDOM_CMDS / PHASES;
            while (cmds_sent < quota)
                run_sequence();
        end

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### files.f
rtl/core/tvps_pkg.sv
rtl/core/tvps_cfg_regs.sv
rtl/core/tvps_div.sv
rtl/core/timed_valve_pulse_sequencer.sv
test/valve_drive_checker.sv
test/tb.sv
